// ----- hw/rtl/bfle_pkg.sv -----
// Shared types, constants and helpers for the byte FIFO line extractor.
// Used by every module of the block but bfle_ram; depends on nothing else.

package bfle_pkg;

  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned MAX_LINE   = 64;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned LEN_W   = 9;

  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned PEND_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_LINE + 2);
  localparam int unsigned CMP_W  = (PEND_W > CNT_W) ? PEND_W : CNT_W;
  localparam int unsigned SUM_W  = CMP_W + 1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [DATA_W-1:0] CH_LF = 8'h0A;
  localparam logic [DATA_W-1:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_LINE  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_NOLINE = 2'd2,
    STAT_EMPTY  = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DELIVER,
    ST_RESP
  } back_state_e;

  typedef struct packed {
    op_e                opcode;
    logic [DATA_W-1:0]  data_byte;
    logic [COUNT_W-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic [LEN_W-1:0]  length;
    stat_e             status;
  } out_item_t;

  // Decoded request as it waits between the front and the back.
  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  amt;
  } cmd_t;

  function automatic logic is_term(logic [DATA_W-1:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic out_item_t mk_res(logic [DATA_W-1:0] b, logic v, logic l,
                                       logic [LEN_W-1:0] len, stat_e s);
    out_item_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.length     = len;
    r.status     = s;
    return r;
  endfunction

endpackage

// ----- hw/rtl/bfle_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the byte store of the line extractor.

module bfle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bfle_front.sv -----
// Front of the line extractor: accepts requests, clamps their counts and
// queues the decoded commands for the back. Depends on bfle_pkg.

module bfle_front import bfle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_pop_i,
  output cmd_t     cmd_o
);

  cmd_t              q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              cmd_in;
  logic [CNT_W-1:0]  clamp;
  logic              push, pop;

  // A line request carries its byte allowance: buffer size minus the
  // terminator slot. A pop carries its clamped byte count.
  always_comb begin
    cmd_in.op   = in_data_i.opcode;
    cmd_in.data = in_data_i.data_byte;
    clamp = (in_data_i.count > COUNT_W'(MAX_LINE)) ? CNT_W'(MAX_LINE)
                                                   : CNT_W'(in_data_i.count);
    unique case (in_data_i.opcode) inside
      OP_POP:            cmd_in.amt = clamp;
      OP_LINE:           cmd_in.amt = (clamp == '0) ? '0 : clamp - 1'b1;
      OP_PUSH, OP_QUERY: cmd_in.amt = '0;
      default:           cmd_in.amt = '0;
    endcase
  end

  assign in_stall_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wptr_q] <= cmd_in;
    end
  end

endmodule

// ----- hw/rtl/bfle_back.sv -----
// Back of the line extractor: owns the byte store, the FIFO pointers and
// the result register, and runs push, pop, line scan and query commands.
// Depends on bfle_pkg and bfle_ram.

module bfle_back import bfle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  back_state_e      state_q, state_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] sp_q, sp_d;
  logic             full_q, full_d;
  logic [CNT_W-1:0] sreq_q, sreq_d;
  logic [CNT_W-1:0] sidx_q, sidx_d;
  logic [CNT_W-1:0] term_q, term_d;
  logic [CNT_W-1:0] toread_q, toread_d;
  logic [CNT_W-1:0] smax_q, smax_d;
  logic [CNT_W-1:0] limit_q, limit_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] dn_q, dn_d;
  logic [CNT_W-1:0] ecnt_q, ecnt_d;
  logic             rvalid_q, rvalid_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  out_item_t        resp_q, resp_d;

  logic              ram_we, ram_re;
  logic [DATA_W-1:0] ram_rdata;

  logic [PEND_W-1:0] pend;
  logic [CMP_W-1:0]  pend_c;
  logic [CNT_W-1:0]  n_pop, toread_n, smax_n;
  logic              out_can_load, emit, req, scan_term;

  logic              scan_go, del_go, resp_go, single_go, cons_go, found_set, deliv_done;
  logic [CNT_W-1:0]  del_n, cons_amt;
  out_item_t         single_item, resp_item;

  function automatic logic [PTR_W-1:0] adv(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] p, logic [CNT_W-1:0] a);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(a);
    if (s >= SUM_W'(FIFO_DEPTH)) begin
      s = s - SUM_W'(FIFO_DEPTH);
    end
    return PTR_W'(s);
  endfunction

  bfle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (sp_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (full_q) begin
      pend = PEND_W'(FIFO_DEPTH);
    end else if (wr_ptr_q >= rd_ptr_q) begin
      pend = PEND_W'(wr_ptr_q) - PEND_W'(rd_ptr_q);
    end else begin
      pend = PEND_W'(FIFO_DEPTH) - PEND_W'(rd_ptr_q) + PEND_W'(wr_ptr_q);
    end
  end

  assign pend_c   = CMP_W'(pend);
  assign n_pop    = (pend_c <= CMP_W'(cmd_i.amt)) ? CNT_W'(pend) : cmd_i.amt;
  assign toread_n = (pend_c <= CMP_W'(cmd_i.amt)) ? CNT_W'(pend) : cmd_i.amt;
  // One read past the allowance lets a doubled terminator be checked.
  assign smax_n   = (pend_c <= CMP_W'(cmd_i.amt) + 1'b1) ? CNT_W'(pend)
                                                          : cmd_i.amt + 1'b1;

  assign out_can_load = !out_valid_q || !out_stall_i;
  assign scan_term    = is_term(ram_rdata);
  assign emit         = (state_q == ST_DELIVER) && rvalid_q && out_can_load;
  assign req          = (state_q == ST_DELIVER) && (cnt_q != '0) && (!rvalid_q || emit);

  // Command decisions shared by the next-state and datapath logic.
  always_comb begin
    cmd_pop_o   = 1'b0;
    scan_go     = 1'b0;
    del_go      = 1'b0;
    resp_go     = 1'b0;
    single_go   = 1'b0;
    cons_go     = 1'b0;
    found_set   = 1'b0;
    deliv_done  = 1'b0;
    del_n       = '0;
    cons_amt    = '0;
    single_item = mk_res('0, 1'b0, 1'b1, '0, STAT_OK);
    resp_item   = mk_res('0, 1'b0, 1'b1, '0, STAT_OK);
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_can_load) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_PUSH: begin
              single_go   = 1'b1;
              single_item = mk_res('0, 1'b0, 1'b1, '0, full_q ? STAT_FULL : STAT_OK);
            end
            OP_POP: begin
              if (n_pop == '0) begin
                single_go   = 1'b1;
                single_item = mk_res('0, 1'b0, 1'b1, '0,
                                     (pend == '0) ? STAT_EMPTY : STAT_OK);
              end else begin
                del_go   = 1'b1;
                del_n    = n_pop;
                cons_go  = 1'b1;
                cons_amt = n_pop;
              end
            end
            OP_LINE: begin
              if (pend == '0) begin
                single_go   = 1'b1;
                single_item = mk_res('0, 1'b0, 1'b1, '0, STAT_EMPTY);
              end else if (cmd_i.amt == '0) begin
                single_go   = 1'b1;
                single_item = mk_res('0, 1'b0, 1'b1, '0, STAT_NOLINE);
              end else begin
                scan_go = 1'b1;
              end
            end
            OP_QUERY: begin
              single_go   = 1'b1;
              single_item = mk_res('0, 1'b0, 1'b1, LEN_W'(pend), STAT_OK);
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (rvalid_q) begin
          if (!found_q) begin
            if (scan_term) begin
              if (CMP_W'(sidx_q) + 1'b1 >= pend_c) begin
                cons_go  = 1'b1;
                cons_amt = sidx_q + 1'b1;
                del_n    = sidx_q;
                del_go   = (sidx_q != '0);
                resp_go  = (sidx_q == '0);
              end else begin
                found_set = 1'b1;
              end
            end else if (sidx_q + 1'b1 == toread_q) begin
              if (toread_q == limit_q) begin
                cons_go  = 1'b1;
                cons_amt = limit_q;
                del_n    = limit_q;
                del_go   = 1'b1;
              end else begin
                resp_go   = 1'b1;
                resp_item = mk_res('0, 1'b0, 1'b1, '0, STAT_NOLINE);
              end
            end
          end else if (sidx_q == term_q + 1'b1) begin
            // A CR or LF right after the terminator goes with the line.
            cons_go  = 1'b1;
            cons_amt = term_q + 1'b1 + CNT_W'(scan_term);
            del_n    = term_q;
            del_go   = (term_q != '0);
            resp_go  = (term_q == '0);
          end
        end
      end
      ST_DELIVER: begin
        deliv_done = emit && (ecnt_q + 1'b1 == dn_q);
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (scan_go) begin
          state_d = ST_SCAN;
        end else if (del_go) begin
          state_d = ST_DELIVER;
        end
      end
      ST_SCAN: begin
        if (del_go) begin
          state_d = ST_DELIVER;
        end else if (resp_go) begin
          state_d = ST_RESP;
        end
      end
      ST_DELIVER: begin
        if (deliv_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    sp_d        = sp_q;
    full_d      = full_q;
    sreq_d      = sreq_q;
    sidx_d      = sidx_q;
    term_d      = term_q;
    toread_d    = toread_q;
    smax_d      = smax_q;
    limit_d     = limit_q;
    cnt_d       = cnt_q;
    dn_d        = dn_q;
    ecnt_d      = ecnt_q;
    rvalid_d    = rvalid_q;
    found_d     = found_q;
    resp_d      = resp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (single_go) begin
          out_d       = single_item;
          out_valid_d = 1'b1;
          if ((cmd_i.op == OP_PUSH) && !full_q) begin
            ram_we   = 1'b1;
            wr_ptr_d = adv(wr_ptr_q);
            full_d   = (adv(wr_ptr_q) == rd_ptr_q);
          end
        end
        if (scan_go) begin
          sp_d     = rd_ptr_q;
          sreq_d   = '0;
          sidx_d   = '0;
          found_d  = 1'b0;
          rvalid_d = 1'b0;
          toread_d = toread_n;
          smax_d   = smax_n;
          limit_d  = cmd_i.amt;
        end
      end
      ST_SCAN: begin
        // Reads stream one byte a cycle; each byte is checked in the cycle after its read.
        ram_re   = (sreq_q < smax_q);
        rvalid_d = ram_re;
        if (ram_re) begin
          sp_d   = adv(sp_q);
          sreq_d = sreq_q + 1'b1;
        end
        if (rvalid_q) begin
          sidx_d = sidx_q + 1'b1;
        end
        if (found_set) begin
          found_d = 1'b1;
          term_d  = sidx_q;
        end
      end
      ST_DELIVER: begin
        ram_re   = req;
        rvalid_d = req || (rvalid_q && !emit);
        if (req) begin
          sp_d  = adv(sp_q);
          cnt_d = cnt_q - 1'b1;
        end
        if (emit) begin
          out_d       = mk_res(ram_rdata, 1'b1, (ecnt_q + 1'b1 == dn_q),
                               LEN_W'(dn_q), STAT_OK);
          out_valid_d = 1'b1;
          ecnt_d      = ecnt_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (out_can_load) begin
          out_d       = resp_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase

    // The consumed span is retired at once; delivery walks a private pointer.
    if (cons_go) begin
      rd_ptr_d = ptr_add(rd_ptr_q, cons_amt);
      if (cons_amt != '0) begin
        full_d = 1'b0;
      end
    end
    if (del_go) begin
      sp_d     = rd_ptr_q;
      cnt_d    = del_n;
      dn_d     = del_n;
      ecnt_d   = '0;
      rvalid_d = 1'b0;
    end
    if (resp_go) begin
      resp_d   = resp_item;
      rvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      sp_q        <= '0;
      full_q      <= 1'b0;
      sreq_q      <= '0;
      sidx_q      <= '0;
      term_q      <= '0;
      toread_q    <= '0;
      smax_q      <= '0;
      limit_q     <= '0;
      cnt_q       <= '0;
      dn_q        <= '0;
      ecnt_q      <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      sp_q        <= sp_d;
      full_q      <= full_d;
      sreq_q      <= sreq_d;
      sidx_q      <= sidx_d;
      term_q      <= term_d;
      toread_q    <= toread_d;
      smax_q      <= smax_d;
      limit_q     <= limit_d;
      cnt_q       <= cnt_d;
      dn_q        <= dn_d;
      ecnt_q      <= ecnt_d;
      rvalid_q    <= rvalid_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    resp_q <= resp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (wr_ptr_q == rd_ptr_q))
    else $error("full flag set while pointers differ");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE) && !full_q)
    else $error("byte store written outside an accepted push");

  a_emit_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> rvalid_q && (ecnt_q < dn_q))
    else $error("line or pop byte emitted without read data");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELIVER) |-> (cnt_q <= dn_q))
    else $error("delivery request count exceeds length");

  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.byte_valid) |-> (out_q.status == STAT_OK))
    else $error("data byte carried with an error status");
`endif

endmodule

// ----- hw/rtl/byte_fifo_line_extractor.sv -----
// Top level of the byte FIFO line extractor.
// Depends on bfle_pkg, bfle_front, bfle_back (and through it bfle_ram).
//
// Usage: requests enter on in_data_i under the in_valid_i/in_stall_o
// handshake (in_valid_i high, in_stall_o low accepts one request). Each
// request is a push, a pop of up to count bytes, a line read or a query of
// the pending count. Results leave on out_data_o under out_valid_o and
// out_stall_i; every request yields at least one result and its final
// result carries last.
// A push, a query, a zero-byte pop or a line read with nothing to scan
// passes through the request queue and gives its result in the result
// register; such requests sustain one per cycle while out_stall_i is low.
// A pop's bytes are read from the store and follow one per cycle while
// out_stall_i is low. A line read first scans the store through its single
// read port, one byte per cycle up to the allowance plus one, then re-reads
// and delivers the line one byte per cycle while out_stall_i is low.
// Reset clears the pointers and the full flag; the store needs no clearing
// pass. While out_stall_i is high the result register holds, the back takes
// no new request, and the two-entry request queue keeps accepting until full.

module byte_fifo_line_extractor import bfle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  bfle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  bfle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- verif/tb_byte_fifo_line_extractor.sv -----
// Self-checking testbench for byte_fifo_line_extractor: pushes, pops, line reads and
// queries are predicted by a behavioral copy of the byte FIFO and checked per result.
// Depends on bfle_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_byte_fifo_line_extractor;
  import bfle_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 200;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  byte_fifo_line_extractor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Behavioral copy of the FIFO state, updated when a request is accepted.
  logic [7:0] fifo_mem [FIFO_DEPTH];
  logic [7:0] wr_ptr;
  logic [7:0] rd_ptr;
  logic       fifo_full;

  out_item_t   expected_results[$];
  int unsigned err_count;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned gap_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic is_line_end(logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic [8:0] fifo_level();
    if (fifo_full) return 9'(FIFO_DEPTH);
    return {1'b0, 8'(wr_ptr - rd_ptr)};
  endfunction

  function automatic out_item_t result_item(logic [7:0] b, logic v, logic l,
                                            logic [8:0] len, stat_e s);
    out_item_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.length     = len;
    r.status     = s;
    return r;
  endfunction

  // Queue n bytes from the read side as results, then drop `consume` bytes.
  task automatic queue_fifo_bytes(input int unsigned n, input int unsigned consume);
    logic [7:0] p;
    p = rd_ptr;
    for (int unsigned i = 0; i < n; i++) begin
      expected_results.push_back(result_item(fifo_mem[p], 1'b1, i + 1 == n, 9'(n), STAT_OK));
      p = p + 8'd1;
    end
    rd_ptr = rd_ptr + 8'(consume);
    if (consume > 0) fifo_full = 1'b0;
    if (n == 0) expected_results.push_back(result_item(8'd0, 1'b0, 1'b1, 9'd0, STAT_OK));
  endtask

  task automatic predict_fifo_results(input in_item_t req);
    int unsigned pend;
    int unsigned amt;
    int unsigned limit;
    int unsigned scan;
    int unsigned consume;
    logic        found;
    logic [7:0]  p;
    pend = fifo_level();
    amt  = req.count;
    case (req.opcode)
      OP_PUSH: begin
        if (fifo_full) begin
          expected_results.push_back(result_item(8'd0, 1'b0, 1'b1, 9'd0, STAT_FULL));
        end else begin
          fifo_mem[wr_ptr] = req.data_byte;
          wr_ptr = wr_ptr + 8'd1;
          if (wr_ptr == rd_ptr) fifo_full = 1'b1;
          expected_results.push_back(result_item(8'd0, 1'b0, 1'b1, 9'd0, STAT_OK));
        end
      end
      OP_POP: begin
        if (amt > pend) amt = pend;
        if (amt > MAX_LINE) amt = MAX_LINE;
        if (amt == 0) begin
          expected_results.push_back(result_item(8'd0, 1'b0, 1'b1, 9'd0,
                                                 (pend == 0) ? STAT_EMPTY : STAT_OK));
        end else begin
          queue_fifo_bytes(amt, amt);
        end
      end
      OP_LINE: begin
        if (pend == 0) begin
          expected_results.push_back(result_item(8'd0, 1'b0, 1'b1, 9'd0, STAT_EMPTY));
        end else begin
          if (amt > MAX_LINE) amt = MAX_LINE;
          limit = (amt == 0) ? 0 : amt - 1;
          scan  = (pend < limit) ? pend : limit;
          p     = rd_ptr;
          found = 1'b0;
          for (int unsigned i = 0; i < scan && !found; i++) begin
            if (is_line_end(fifo_mem[p])) begin
              // A second CR or LF right after the terminator goes with it.
              consume = i + 1;
              if (consume < pend && is_line_end(fifo_mem[8'(p + 8'd1)])) consume++;
              queue_fifo_bytes(i, consume);
              found = 1'b1;
            end
            p = p + 8'd1;
          end
          if (!found) begin
            if (limit > 0 && scan == limit) queue_fifo_bytes(limit, limit);
            else expected_results.push_back(result_item(8'd0, 1'b0, 1'b1, 9'd0,
                                                        STAT_NOLINE));
          end
        end
      end
      default: begin
        expected_results.push_back(result_item(8'd0, 1'b0, 1'b1, 9'(pend), STAT_OK));
      end
    endcase
  endtask

  task automatic send_req(input op_e op, input logic [7:0] b, input logic [6:0] n);
    in_item_t req;
    req.opcode    = op;
    req.data_byte = b;
    req.count     = n;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_fifo_results(req);
    items_sent++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    send_req(OP_PUSH, b, 7'($urandom_range(0, 64)));
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (is_line_end(b)) b = 8'($urandom);
    return b;
  endfunction

  // Push len ordinary bytes followed by one of several terminator forms,
  // or by none at all, which leaves a partial line pending.
  task automatic push_text_line(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_byte(text_byte());
    case ($urandom_range(0, 5))
      0: push_byte(CH_LF);
      1: push_byte(CH_CR);
      2: begin push_byte(CH_CR); push_byte(CH_LF); end
      3: begin push_byte(CH_LF); push_byte(CH_CR); end
      4: begin push_byte(CH_CR); push_byte(CH_CR); end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", out_data_o.out_byte, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.out_byte != want.out_byte)
          report_mismatch("out_byte", out_data_o.out_byte, want.out_byte);
        if (out_data_o.byte_valid != want.byte_valid)
          report_mismatch("byte_valid", out_data_o.byte_valid, want.byte_valid);
        if (out_data_o.last != want.last)
          report_mismatch("last", out_data_o.last, want.last);
        if (out_data_o.length != want.length)
          report_mismatch("length", out_data_o.length, want.length);
        if (out_data_o.status != want.status)
          report_mismatch("status", out_data_o.status, want.status);
      end
    end
  end

  initial begin : out_stall_gen
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_byte_fifo_line_extractor failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_fifo();
    send_req(OP_POP, 8'h00, 7'd64);
    send_req(OP_POP, 8'hFF, 7'd0);
    send_req(OP_LINE, 8'h5A, 7'd64);
    send_req(OP_QUERY, 8'hA5, 7'd1);
  endtask

  task automatic test_directed_lines();
    push_byte(8'h00);
    push_byte(8'hFF);
    send_req(OP_POP, 8'h00, 7'd0);       // bytes pending but none asked for
    send_req(OP_QUERY, 8'h00, 7'd0);
    send_req(OP_POP, 8'h00, 7'd64);
    push_byte("a");
    push_byte(CH_CR);
    push_byte(CH_LF);
    send_req(OP_LINE, 8'h00, 7'd0);      // no room for any line byte
    send_req(OP_LINE, 8'h00, 7'd1);
    send_req(OP_LINE, 8'h00, 7'd64);     // "a" with the CR LF pair consumed
    push_byte(CH_LF);
    push_byte(CH_LF);
    push_byte(CH_LF);
    send_req(OP_LINE, 8'h00, 7'd64);     // empty line eats two terminators
    send_req(OP_LINE, 8'h00, 7'd64);     // last terminator has no follower
    push_byte("x");
    push_byte("y");
    push_byte("z");
    send_req(OP_LINE, 8'h00, 7'd3);      // line too long for the buffer
    send_req(OP_LINE, 8'h00, 7'd64);     // partial line stays pending
    send_req(OP_LINE, 8'h00, 7'd2);
    push_byte(CH_CR);
    push_byte(CH_CR);
    push_byte("q");
    send_req(OP_LINE, 8'h00, 7'd64);
    send_req(OP_POP, 8'h00, 7'd64);
  endtask

  // Fill to the full flag, overflow, and drain with saturating pops.
  task automatic test_full_fifo();
    for (int unsigned i = 0; i < FIFO_DEPTH; i++) push_byte(text_byte());
    push_byte(8'h42);
    send_req(OP_QUERY, 8'h00, 7'd0);
    send_req(OP_LINE, 8'h00, 7'd64);
    send_req(OP_QUERY, 8'h00, 7'd0);
    while (fifo_level() != 0) send_req(OP_POP, 8'h00, 7'd64);
  endtask

  task automatic run_traffic(input int unsigned n_items, input logic vary_gaps);
    int unsigned stop_at;
    int unsigned sel;
    int unsigned len;
    int unsigned lo;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if (vary_gaps && $urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      sel = $urandom_range(0, 99);
      if (fifo_level() > 180) begin
        send_req(OP_POP, 8'($urandom), 7'd64);
      end else if (sel < 55) begin
        case ($urandom_range(0, 9))
          0: len = 0;
          1: len = $urandom_range(55, 70);
          default: len = $urandom_range(1, 20);
        endcase
        push_text_line(len);
        if ($urandom_range(0, 1) == 0) begin
          lo = (len + 2 > MAX_LINE) ? MAX_LINE : len + 2;
          if ($urandom_range(0, 4) == 0) lo = 0;
          send_req(OP_LINE, 8'($urandom), 7'($urandom_range(lo, MAX_LINE)));
        end
      end else if (sel < 70) begin
        send_req(OP_LINE, 8'($urandom), 7'($urandom_range(0, MAX_LINE)));
      end else if (sel < 82) begin
        send_req(OP_POP, 8'($urandom), 7'($urandom_range(0, MAX_LINE)));
      end else if (sel < 90) begin
        send_req(OP_QUERY, 8'($urandom), 7'($urandom_range(0, MAX_LINE)));
      end else begin
        push_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(40, 1'b1);
  endtask

  task automatic test_back_to_back();
    gap_pct = 0;
    run_traffic(20, 1'b0);
  endtask

  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    rst_ni      = 1'b0;
    wr_ptr      = '0;
    rd_ptr      = '0;
    fifo_full   = 1'b0;
    err_count   = 0;
    items_sent  = 0;
    idle_cycles = 0;
    gap_pct     = 20;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_fifo();
    test_directed_lines();
    test_full_fifo();
    test_random_traffic();
    test_back_to_back();

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_byte_fifo_line_extractor passed");
    end else begin
      $display("tb_byte_fifo_line_extractor failed");
    end
    $finish;
  end

endmodule
